>>> hdl/assert_macros.svh
// Assertion helpers used by the checker file lvt_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hdl/lvt_pkg.sv
package lvt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int QW        = 18;
    localparam int VW        = 24;
    localparam int IDXW      = 3;
    localparam int CFG_DW    = 24;

    // quaternion product, full matrix entry, truncated entry
    localparam int QPW = 2 * QW;
    localparam int MFW = ((QW > FRAC_BITS) ? 2 * QW : 2 * FRAC_BITS) + 2;
    localparam int MW  = MFW - FRAC_BITS;
    // lane products and accumulator
    localparam int PW  = MW + VW;
    localparam int CW  = 2 * VW;
    localparam int AW  = ((PW > CW) ? PW : CW) + 3;
    localparam int SW  = AW - FRAC_BITS;

    // cycles the matrix needs to follow a register write
    localparam int WARMUP = 2;
    localparam int WCW    = $clog2(WARMUP + 1);

    typedef logic signed [QW-1:0]  t_quat;
    typedef logic signed [VW-1:0]  t_vec;
    typedef logic signed [QPW-1:0] t_qprod;
    typedef logic signed [MFW-1:0] t_mfull;
    typedef logic signed [MW-1:0]  t_mat_elem;
    typedef logic signed [PW-1:0]  t_prod;
    typedef logic signed [CW-1:0]  t_cross;
    typedef logic signed [AW-1:0]  t_acc;
    typedef logic signed [SW-1:0]  t_scaled;

    typedef struct packed {
        t_vec meas_vel_x;
        t_vec meas_vel_y;
        t_vec meas_vel_z;
        t_vec ang_rate_x;
        t_vec ang_rate_y;
        t_vec ang_rate_z;
    } t_in_item;

    typedef struct packed {
        t_vec out_vel_x;
        t_vec out_vel_y;
        t_vec out_vel_z;
        logic overflow;
    } t_out_item;

    typedef struct packed {
        logic en1;
        logic en2;
    } t_lane_en;

    typedef enum logic [IDXW-1:0] {
        REG_QUAT_W  = 3'd0,
        REG_QUAT_X  = 3'd1,
        REG_QUAT_Y  = 3'd2,
        REG_QUAT_Z  = 3'd3,
        REG_LEVER_X = 3'd4,
        REG_LEVER_Y = 3'd5,
        REG_LEVER_Z = 3'd6
    } t_reg_idx;

    localparam t_quat  QUAT_ONE = t_quat'(64'sd1 <<< FRAC_BITS);
    localparam t_mfull ONE2     = t_mfull'(1) <<< (2 * FRAC_BITS);
    localparam t_vec   VEL_MAX  = {1'b0, {(VW-1){1'b1}}};
    localparam t_vec   VEL_MIN  = {1'b1, {(VW-1){1'b0}}};

endpackage

>>> hdl/lvt_if.sv
interface lvt_in_if;
    import lvt_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item item;
    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface lvt_out_if;
    import lvt_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item item;
    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface lvt_cfg_if;
    import lvt_pkg::*;
    logic              valid;
    logic              ready;
    logic [IDXW-1:0]   index;
    logic [CFG_DW-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/lvt_mat.sv
module lvt_mat (
    input  logic              i_clk,
    input  lvt_pkg::t_quat    i_q_w,
    input  lvt_pkg::t_quat    i_q_x,
    input  lvt_pkg::t_quat    i_q_y,
    input  lvt_pkg::t_quat    i_q_z,
    output lvt_pkg::t_mat_elem o_mat [3][3]
);
    import lvt_pkg::*;

    t_qprod r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    t_mat_elem n_mat [3][3];
    t_mat_elem r_mat [3][3];

    function automatic t_mat_elem diag_entry(t_qprod a, t_qprod b);
        t_mfull full;
        full = ONE2 - ((t_mfull'(a) + t_mfull'(b)) <<< 1);
        return t_mat_elem'(full >>> FRAC_BITS);
    endfunction

    function automatic t_mat_elem off_entry(t_qprod a, t_qprod b, logic sub);
        t_mfull full;
        full = sub ? (t_mfull'(a) - t_mfull'(b)) : (t_mfull'(a) + t_mfull'(b));
        full = full <<< 1;
        return t_mat_elem'(full >>> FRAC_BITS);
    endfunction

    // stage A: quaternion products
    always_ff @(posedge i_clk) begin
        r_xx <= t_qprod'(i_q_x) * t_qprod'(i_q_x);
        r_yy <= t_qprod'(i_q_y) * t_qprod'(i_q_y);
        r_zz <= t_qprod'(i_q_z) * t_qprod'(i_q_z);
        r_xy <= t_qprod'(i_q_x) * t_qprod'(i_q_y);
        r_xz <= t_qprod'(i_q_x) * t_qprod'(i_q_z);
        r_yz <= t_qprod'(i_q_y) * t_qprod'(i_q_z);
        r_wx <= t_qprod'(i_q_w) * t_qprod'(i_q_x);
        r_wy <= t_qprod'(i_q_w) * t_qprod'(i_q_y);
        r_wz <= t_qprod'(i_q_w) * t_qprod'(i_q_z);
    end

    // stage B: rotation matrix entries, truncated to the fraction width
    always_comb begin
        n_mat[0][0] = diag_entry(r_yy, r_zz);
        n_mat[0][1] = off_entry(r_xy, r_wz, 1'b1);
        n_mat[0][2] = off_entry(r_xz, r_wy, 1'b0);
        n_mat[1][0] = off_entry(r_xy, r_wz, 1'b0);
        n_mat[1][1] = diag_entry(r_xx, r_zz);
        n_mat[1][2] = off_entry(r_yz, r_wx, 1'b1);
        n_mat[2][0] = off_entry(r_xz, r_wy, 1'b1);
        n_mat[2][1] = off_entry(r_yz, r_wx, 1'b0);
        n_mat[2][2] = diag_entry(r_xx, r_yy);
    end

    always_ff @(posedge i_clk) begin
        r_mat <= n_mat;
    end

    assign o_mat = r_mat;

endmodule

>>> hdl/lvt_lane.sv
module lvt_lane (
    input  logic                i_clk,
    input  lvt_pkg::t_lane_en   i_en,
    input  lvt_pkg::t_mat_elem  i_row [3],
    input  lvt_pkg::t_vec       i_vel [3],
    input  lvt_pkg::t_vec       i_rate_a,
    input  lvt_pkg::t_vec       i_lever_b,
    input  lvt_pkg::t_vec       i_rate_b,
    input  lvt_pkg::t_vec       i_lever_a,
    output lvt_pkg::t_acc       o_acc
);
    import lvt_pkg::*;

    t_prod  r_p0, r_p1, r_p2;
    t_cross r_c_pos, r_c_neg;
    t_acc   r_acc;
    t_acc   n_acc;

    // stage 1: row times velocity, and the two cross-product terms
    always_ff @(posedge i_clk) begin
        if (i_en.en1) begin
            r_p0    <= t_prod'(i_row[0]) * t_prod'(i_vel[0]);
            r_p1    <= t_prod'(i_row[1]) * t_prod'(i_vel[1]);
            r_p2    <= t_prod'(i_row[2]) * t_prod'(i_vel[2]);
            r_c_pos <= t_cross'(i_rate_a) * t_cross'(i_lever_b);
            r_c_neg <= t_cross'(i_rate_b) * t_cross'(i_lever_a);
        end
    end

    // subtract rate x lever: rate_a*lever_b - rate_b*lever_a
    assign n_acc = t_acc'(r_p0) + t_acc'(r_p1) + t_acc'(r_p2)
                 - t_acc'(r_c_pos) + t_acc'(r_c_neg);

    always_ff @(posedge i_clk) begin
        if (i_en.en2) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

>>> hdl/lvt_merge.sv
module lvt_merge (
    input  logic                i_clk,
    input  logic                i_en,
    input  lvt_pkg::t_acc       i_acc [3],
    output lvt_pkg::t_out_item  o_item
);
    import lvt_pkg::*;

    t_scaled   w_scaled [3];
    t_vec      w_sat    [3];
    logic      w_ovf    [3];
    t_out_item n_item;
    t_out_item r_item;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_scaled[i] = t_scaled'(i_acc[i] >>> FRAC_BITS);
            if (w_scaled[i] > t_scaled'(VEL_MAX)) begin
                w_sat[i] = VEL_MAX;
                w_ovf[i] = 1'b1;
            end else if (w_scaled[i] < t_scaled'(VEL_MIN)) begin
                w_sat[i] = VEL_MIN;
                w_ovf[i] = 1'b1;
            end else begin
                w_sat[i] = w_scaled[i][VW-1:0];
                w_ovf[i] = 1'b0;
            end
        end
        n_item.out_vel_x = w_sat[0];
        n_item.out_vel_y = w_sat[1];
        n_item.out_vel_z = w_sat[2];
        n_item.overflow  = w_ovf[0] | w_ovf[1] | w_ovf[2];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

>>> hdl/lever_arm_velocity_transform.sv
// Rotates a measured sensor-frame velocity into the vehicle frame with the
// configured mounting quaternion, then removes the rate-times-lever-arm term:
// out = R(q) * v - (w x l), Q8.16 fixed point, truncated, saturated to 24 bits,
// with overflow set when any component clipped. When the output side is not
// stalled and input ready is high, one item per cycle enters a four-stage
// pipeline (input register, products, sum, saturate/output register); its
// result is valid once it reaches the output register, and bubbles are
// absorbed stage by stage. The rotation matrix is derived from the quaternion
// registers in two clocked stages, so input ready stays low after reset and
// after every register write while the matrix settles. Register writes are
// taken every cycle; indexes above lever_arm_z are ignored.
module lever_arm_velocity_transform (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lvt_cfg_if.sink    i_cfg,
    lvt_in_if.sink     i_in,
    lvt_out_if.source  o_out
);
    import lvt_pkg::*;

    t_quat r_q_w, r_q_x, r_q_y, r_q_z;
    t_vec  r_lever_x, r_lever_y, r_lever_z;
    logic [WCW-1:0] r_warm;

    logic r_v0, r_v1, r_v2, r_v3;
    logic w_en0, w_en1, w_en2, w_en3;
    logic w_in_fire, w_cfg_fire;
    t_in_item r_item;

    t_mat_elem w_mat [3][3];
    t_vec      w_vel [3];
    t_acc      w_acc [3];
    t_lane_en  w_lane_en;

    assign w_cfg_fire  = i_cfg.valid & i_cfg.ready;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_w     <= QUAT_ONE;
            r_q_x     <= '0;
            r_q_y     <= '0;
            r_q_z     <= '0;
            r_lever_x <= '0;
            r_lever_y <= '0;
            r_lever_z <= '0;
        end else if (w_cfg_fire) begin
            unique case (t_reg_idx'(i_cfg.index))
                REG_QUAT_W:  r_q_w     <= t_quat'(i_cfg.data[QW-1:0]);
                REG_QUAT_X:  r_q_x     <= t_quat'(i_cfg.data[QW-1:0]);
                REG_QUAT_Y:  r_q_y     <= t_quat'(i_cfg.data[QW-1:0]);
                REG_QUAT_Z:  r_q_z     <= t_quat'(i_cfg.data[QW-1:0]);
                REG_LEVER_X: r_lever_x <= t_vec'(i_cfg.data[VW-1:0]);
                REG_LEVER_Y: r_lever_y <= t_vec'(i_cfg.data[VW-1:0]);
                REG_LEVER_Z: r_lever_z <= t_vec'(i_cfg.data[VW-1:0]);
                default: ;
            endcase
        end
    end

    // hold input off until the matrix reflects the registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warm <= WCW'(WARMUP);
        end else if (w_cfg_fire) begin
            r_warm <= WCW'(WARMUP);
        end else if (r_warm != '0) begin
            r_warm <= r_warm - 1'b1;
        end
    end

    // a stage advances when it is empty or the next one advances
    assign w_en3 = ~r_v3 | o_out.ready;
    assign w_en2 = ~r_v2 | w_en3;
    assign w_en1 = ~r_v1 | w_en2;
    assign w_en0 = ~r_v0 | w_en1;

    assign i_in.ready = w_en0 & (r_warm == '0);
    assign w_in_fire  = i_in.valid & i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en0) r_v0 <= w_in_fire;
            if (w_en1) r_v1 <= r_v0;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en0) begin
            r_item <= i_in.item;
        end
    end

    lvt_mat u_mat (
        .i_clk (i_clk),
        .i_q_w (r_q_w),
        .i_q_x (r_q_x),
        .i_q_y (r_q_y),
        .i_q_z (r_q_z),
        .o_mat (w_mat)
    );

    assign w_vel[0] = r_item.meas_vel_x;
    assign w_vel[1] = r_item.meas_vel_y;
    assign w_vel[2] = r_item.meas_vel_z;

    assign w_lane_en.en1 = w_en1;
    assign w_lane_en.en2 = w_en2;

    // x: wy*lz - wz*ly
    lvt_lane u_lane_x (
        .i_clk     (i_clk),
        .i_en      (w_lane_en),
        .i_row     (w_mat[0]),
        .i_vel     (w_vel),
        .i_rate_a  (r_item.ang_rate_y),
        .i_lever_b (r_lever_z),
        .i_rate_b  (r_item.ang_rate_z),
        .i_lever_a (r_lever_y),
        .o_acc     (w_acc[0])
    );

    // y: wz*lx - wx*lz
    lvt_lane u_lane_y (
        .i_clk     (i_clk),
        .i_en      (w_lane_en),
        .i_row     (w_mat[1]),
        .i_vel     (w_vel),
        .i_rate_a  (r_item.ang_rate_z),
        .i_lever_b (r_lever_x),
        .i_rate_b  (r_item.ang_rate_x),
        .i_lever_a (r_lever_z),
        .o_acc     (w_acc[1])
    );

    // z: wx*ly - wy*lx
    lvt_lane u_lane_z (
        .i_clk     (i_clk),
        .i_en      (w_lane_en),
        .i_row     (w_mat[2]),
        .i_vel     (w_vel),
        .i_rate_a  (r_item.ang_rate_x),
        .i_lever_b (r_lever_y),
        .i_rate_b  (r_item.ang_rate_y),
        .i_lever_a (r_lever_x),
        .o_acc     (w_acc[2])
    );

    lvt_merge u_merge (
        .i_clk  (i_clk),
        .i_en   (w_en3),
        .i_acc  (w_acc),
        .o_item (o_out.item)
    );

    assign o_out.valid = r_v3;

endmodule

>>> hdl/lvt_checker.sv
`include "assert_macros.svh"

module lvt_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input lvt_pkg::t_out_item  i_out_item,
    input logic                i_cfg_valid,
    input logic                i_cfg_ready
);
    import lvt_pkg::*;

    logic w_in_range;

    assign w_in_range = (i_out_item.out_vel_x != VEL_MAX) && (i_out_item.out_vel_x != VEL_MIN)
                     && (i_out_item.out_vel_y != VEL_MAX) && (i_out_item.out_vel_y != VEL_MIN)
                     && (i_out_item.out_vel_z != VEL_MAX) && (i_out_item.out_vel_z != VEL_MIN);

    // a stalled result beat holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_item))

    // input stays closed while the matrix follows a register write
    `ASSERT_NEXT(a_cfg_blocks_in, i_clk, i_rst_n, i_cfg_valid && i_cfg_ready, !i_in_ready)

    // input stays closed right after reset
    `ASSERT_IMPLIES(a_rst_blocks_in, i_clk, i_rst_n, $past(i_rst_n) == 1'b0, !i_in_ready)

    // no clipped component, no overflow
    `ASSERT_IMPLIES(a_ovf_only_at_limit, i_clk, i_rst_n, i_out_valid && w_in_range, !i_out_item.overflow)

endmodule

bind lever_arm_velocity_transform lvt_checker u_lvt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_item  (o_out.item),
    .i_cfg_valid (i_cfg.valid),
    .i_cfg_ready (i_cfg.ready)
);

>>> dv/tb_lever_arm_velocity_transform.sv
module tb_lever_arm_velocity_transform;
    timeunit 1ns;
    timeprecision 1ps;

    import lvt_pkg::*;

    localparam logic [IDXW-1:0] REG_NONE = 3'd7;   // no register behind this index
    localparam int DRAIN_CYCLES = 16;
    localparam int IDLE_CYCLES  = 8;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    lvt_in_if  in_bus();
    lvt_out_if out_bus();
    lvt_cfg_if cfg_bus();

    lever_arm_velocity_transform uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // mirror of the register file
    longint mq_w, mq_x, mq_y, mq_z;
    longint arm_x, arm_y, arm_z;

    t_out_item           expected_vel_q[$];
    logic [IDXW-1:0]     wr_idx_q[$];
    logic [CFG_DW-1:0]   wr_data_q[$];
    int                  mismatch_count = 0;
    bit                  calm = 1'b0;
    int                  hold_req = 0;

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic void apply_reg(logic [IDXW-1:0] idx, logic [CFG_DW-1:0] data);
        case (idx)
            REG_QUAT_W:  mq_w  = t_quat'(data[QW-1:0]);
            REG_QUAT_X:  mq_x  = t_quat'(data[QW-1:0]);
            REG_QUAT_Y:  mq_y  = t_quat'(data[QW-1:0]);
            REG_QUAT_Z:  mq_z  = t_quat'(data[QW-1:0]);
            REG_LEVER_X: arm_x = t_vec'(data[VW-1:0]);
            REG_LEVER_Y: arm_y = t_vec'(data[VW-1:0]);
            REG_LEVER_Z: arm_z = t_vec'(data[VW-1:0]);
            default: ;
        endcase
    endfunction

    function automatic t_out_item transform_velocity(t_in_item it);
        longint    v[3];
        longint    m[3][3];
        longint    cr[3];
        longint    one2, rx, ry, rz, acc, r;
        t_vec      lane[3];
        t_out_item res;
        one2 = longint'(1) <<< (2 * FRAC_BITS);
        v[0] = it.meas_vel_x;
        v[1] = it.meas_vel_y;
        v[2] = it.meas_vel_z;
        rx   = it.ang_rate_x;
        ry   = it.ang_rate_y;
        rz   = it.ang_rate_z;
        m[0][0] = one2 - 2 * (mq_y * mq_y + mq_z * mq_z);
        m[0][1] = 2 * (mq_x * mq_y - mq_w * mq_z);
        m[0][2] = 2 * (mq_x * mq_z + mq_w * mq_y);
        m[1][0] = 2 * (mq_x * mq_y + mq_w * mq_z);
        m[1][1] = one2 - 2 * (mq_x * mq_x + mq_z * mq_z);
        m[1][2] = 2 * (mq_y * mq_z - mq_w * mq_x);
        m[2][0] = 2 * (mq_x * mq_z - mq_w * mq_y);
        m[2][1] = 2 * (mq_y * mq_z + mq_w * mq_x);
        m[2][2] = one2 - 2 * (mq_x * mq_x + mq_y * mq_y);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                m[i][j] = m[i][j] >>> FRAC_BITS;
        cr[0] = ry * arm_z - rz * arm_y;
        cr[1] = rz * arm_x - rx * arm_z;
        cr[2] = rx * arm_y - ry * arm_x;
        res = '0;
        for (int i = 0; i < 3; i++) begin
            acc = m[i][0] * v[0] + m[i][1] * v[1] + m[i][2] * v[2] - cr[i];
            r = acc >>> FRAC_BITS;
            if (r > longint'(VEL_MAX)) begin
                r = VEL_MAX;
                res.overflow = 1'b1;
            end else if (r < longint'(VEL_MIN)) begin
                r = VEL_MIN;
                res.overflow = 1'b1;
            end
            lane[i] = t_vec'(r);
        end
        res.out_vel_x = lane[0];
        res.out_vel_y = lane[1];
        res.out_vel_z = lane[2];
        return res;
    endfunction

    function automatic t_in_item mk_item(t_vec vx, t_vec vy, t_vec vz,
                                         t_vec rx, t_vec ry, t_vec rz);
        t_in_item it;
        it.meas_vel_x = vx;
        it.meas_vel_y = vy;
        it.meas_vel_z = vz;
        it.ang_rate_x = rx;
        it.ang_rate_y = ry;
        it.ang_rate_z = rz;
        return it;
    endfunction

    // mostly small magnitudes, some full-range and rail values
    function automatic t_vec rand_comp(int scale);
        int r;
        int s;
        r = $urandom_range(0, 99);
        if (r < 4) return VEL_MAX;
        if (r < 8) return VEL_MIN;
        if (r < 25) return t_vec'($urandom);
        s = $urandom_range(0, (1 << (scale + 1)) - 1) - (1 << scale);
        return t_vec'(s);
    endfunction

    function automatic t_in_item rand_item();
        return mk_item(rand_comp(20), rand_comp(20), rand_comp(20),
                       rand_comp(17), rand_comp(17), rand_comp(17));
    endfunction

    task automatic send_item(t_in_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_bus.valid <= 1'b1;
        in_bus.item  <= it;
        do @(posedge i_clk); while (!in_bus.ready);
        expected_vel_q.push_back(transform_velocity(it));
    endtask

    task automatic finish_burst();
        in_bus.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        while (expected_vel_q.size() != 0) @(posedge i_clk);
        repeat (IDLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic void queue_write(logic [IDXW-1:0] idx, logic [CFG_DW-1:0] data);
        wr_idx_q.push_back(idx);
        wr_data_q.push_back(data);
    endfunction

    // send every pending register write back to back, block idle
    task automatic flush_writes();
        wait_idle();
        while (wr_idx_q.size() != 0) begin
            cfg_bus.valid <= 1'b1;
            cfg_bus.index <= wr_idx_q[0];
            cfg_bus.data  <= wr_data_q[0];
            do @(posedge i_clk); while (!cfg_bus.ready);
            apply_reg(wr_idx_q.pop_front(), wr_data_q.pop_front());
        end
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic set_quat(int w, int x, int y, int z);
        queue_write(REG_QUAT_W, CFG_DW'(w));
        queue_write(REG_QUAT_X, CFG_DW'(x));
        queue_write(REG_QUAT_Y, CFG_DW'(y));
        queue_write(REG_QUAT_Z, CFG_DW'(z));
    endtask

    task automatic set_lever(int x, int y, int z);
        queue_write(REG_LEVER_X, CFG_DW'(x));
        queue_write(REG_LEVER_Y, CFG_DW'(y));
        queue_write(REG_LEVER_Z, CFG_DW'(z));
    endtask

    function automatic int rand_lever();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return 8388607;
        if (r < 10) return -8388608;
        if (r < 20) return int'($urandom);
        return $urandom_range(0, (1 << 19) - 1) - (1 << 18);
    endfunction

    // reset values: identity rotation, zero lever arm, so output follows input
    task automatic test_identity_passthrough();
        send_item(mk_item(0, 0, 0, 0, 0, 0));
        send_item(mk_item(VEL_MAX, VEL_MAX, VEL_MAX, VEL_MAX, VEL_MAX, VEL_MAX));
        send_item(mk_item(VEL_MIN, VEL_MIN, VEL_MIN, VEL_MIN, VEL_MIN, VEL_MIN));
        send_item(mk_item(24'h555555, 24'hAAAAAA, 24'h555555,
                          24'hAAAAAA, 24'h555555, 24'hAAAAAA));
        send_item(mk_item(-1, 1, -65536, 65536, -1, 1));
        finish_burst();
    endtask

    // rails on the lever arm drive the cross term into saturation both ways
    task automatic test_lever_cross_term();
        set_quat(65536, 0, 0, 0);
        set_lever(8388607, -8388608, 8388607);
        flush_writes();
        send_item(mk_item(0, 0, 0, VEL_MAX, VEL_MAX, VEL_MAX));
        send_item(mk_item(0, 0, 0, VEL_MIN, VEL_MIN, VEL_MIN));
        send_item(mk_item(VEL_MAX, VEL_MIN, 0, VEL_MIN, VEL_MAX, 0));
        send_item(mk_item(65536, -65536, 131072, 256, -256, 1));
        finish_burst();
    endtask

    // quaternion left unnormalized, at both rails, then a proper 90 degree turn
    task automatic test_nonunit_quaternion();
        set_quat(131071, 131071, 131071, 131071);
        set_lever(0, 0, 0);
        flush_writes();
        send_item(mk_item(VEL_MAX, VEL_MAX, VEL_MAX, 0, 0, 0));
        send_item(mk_item(VEL_MIN, 1, -1, 0, 0, 0));
        finish_burst();
        set_quat(-131072, -131072, -131072, -131072);
        flush_writes();
        send_item(mk_item(VEL_MIN, VEL_MIN, VEL_MIN, 0, 0, 0));
        send_item(mk_item(4096, -4096, 4096, 0, 0, 0));
        finish_burst();
        set_quat(46341, 0, 0, 46341);
        set_lever(65536, 0, 0);
        flush_writes();
        send_item(mk_item(65536, 0, 0, 0, 0, 65536));
        send_item(mk_item(VEL_MAX, VEL_MIN, VEL_MAX, 0, 0, VEL_MIN));
        finish_burst();
    endtask

    // unknown index is dropped; upper data bits of the quaternion are dropped
    task automatic test_register_corner_bits();
        set_quat(24'hFD0000, 24'hFE0000 | 24'h00C000, 24'hA40000, 24'h7C8000);
        set_lever(0, 0, 0);
        queue_write(REG_NONE, 24'hFFFFFF);
        flush_writes();
        send_item(mk_item(65536, 65536, 65536, 0, 0, 0));
        send_item(mk_item(VEL_MAX, 0, VEL_MIN, 65536, 65536, 65536));
        finish_burst();
        queue_write(REG_NONE, 24'h123456);
        queue_write(REG_LEVER_Y, 24'h800001);
        flush_writes();
        send_item(mk_item(1, -1, 1, VEL_MAX, 0, VEL_MIN));
        finish_burst();
    endtask

    // receiver holds off while the sender keeps pushing, so input stalls
    task automatic test_backpressure();
        set_quat(32768, 32768, 32768, 32768);
        set_lever(rand_lever(), rand_lever(), rand_lever());
        flush_writes();
        calm = 1'b1;
        hold_req = 250;
        repeat (60) send_item(rand_item());
        finish_burst();
        calm = 1'b0;
    endtask

    task automatic random_setting(int kind);
        int w, x, y, z;
        if (kind == 0) begin
            set_quat(131071, 131071, 131071, 131071);
            set_lever(8388607, 8388607, 8388607);
        end else if (kind == 1) begin
            set_quat(-131072, -131072, -131072, -131072);
            set_lever(-8388608, -8388608, -8388608);
        end else begin
            if ($urandom_range(0, 9) < 6) begin
                case ($urandom_range(0, 6))
                    0: begin w = 65536; x = 0;      y = 0;      z = 0;      end
                    1: begin w = 46341; x = 46341;  y = 0;      z = 0;      end
                    2: begin w = 46341; x = 0;      y = 46341;  z = 0;      end
                    3: begin w = 46341; x = 0;      y = 0;      z = 46341;  end
                    4: begin w = 0;     x = 65536;  y = 0;      z = 0;      end
                    5: begin w = 32768; x = 32768;  y = 32768;  z = 32768;  end
                    default: begin w = 32768; x = -32768; y = 32768; z = -32768; end
                endcase
                if ($urandom_range(0, 1) == 1) begin
                    w = -w; x = -x; y = -y; z = -z;
                end
                set_quat(w, x, y, z);
            end else begin
                set_quat(int'($urandom), int'($urandom), int'($urandom), int'($urandom));
            end
            set_lever(rand_lever(), rand_lever(), rand_lever());
            if ($urandom_range(0, 2) == 0)
                queue_write(REG_NONE, CFG_DW'($urandom));
        end
        flush_writes();
    endtask

    task automatic test_random_stream();
        for (int phase = 0; phase < 8; phase++) begin
            random_setting(phase);
            calm = ($urandom_range(0, 3) == 0);
            repeat (250) send_item(rand_item());
            finish_burst();
        end
        calm = 1'b0;
    endtask

    function automatic void check_lane(string lane_name, t_vec want, t_vec got);
        if (want !== got) begin
            $display("%0t: %s expected %0d actual %0d", $time, lane_name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin : check_results
        t_out_item want;
        t_out_item got;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            got = out_bus.item;
            if (expected_vel_q.size() == 0) begin
                $display("%0t: unexpected result beat, actual %0d %0d %0d ovf %0b", $time,
                         got.out_vel_x, got.out_vel_y, got.out_vel_z, got.overflow);
                mismatch_count++;
            end else begin
                want = expected_vel_q.pop_front();
                check_lane("out_vel_x", want.out_vel_x, got.out_vel_x);
                check_lane("out_vel_y", want.out_vel_y, got.out_vel_y);
                check_lane("out_vel_z", want.out_vel_z, got.out_vel_z);
                if (want.overflow !== got.overflow) begin
                    $display("%0t: overflow expected %0b actual %0b", $time,
                             want.overflow, got.overflow);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : drain_results
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        out_bus.ready = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                out_bus.ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                out_bus.ready <= 1'b0;
                stall_left--;
            end else begin
                out_bus.ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    initial begin
        #30_000_000;
        $display("tb_lever_arm_velocity_transform: errors");
        $finish;
    end

    initial begin
        in_bus.valid  = 1'b0;
        in_bus.item   = '0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = '0;
        cfg_bus.data  = '0;
        mq_w  = longint'(QUAT_ONE);
        mq_x  = 0;
        mq_y  = 0;
        mq_z  = 0;
        arm_x = 0;
        arm_y = 0;
        arm_z = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_identity_passthrough();
        test_lever_cross_term();
        test_nonunit_quaternion();
        test_register_corner_bits();
        test_backpressure();
        test_random_stream();

        while (expected_vel_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb_lever_arm_velocity_transform: clean");
        end else begin
            $display("tb_lever_arm_velocity_transform: errors");
        end
        $finish;
    end

endmodule
